// File: rtl/sliding_window_median_core_macros.svh
// Assertion macros for the sliding window median core.
// Used by the top level only; needs a clock named clk and a reset named rst in scope.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window median core.
// No dependencies; used by swm_cell and sliding_window_median_core.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned AGE_BITS    = $clog2(WINDOW_MAX);
  localparam int unsigned IDX_BITS    = $clog2(WINDOW_MAX);
  localparam int unsigned FILL_BITS   = $clog2(WINDOW_MAX + 1);

  localparam logic [FILL_BITS-1:0] WINDOW_RESET = FILL_BITS'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0]           age_t;
  typedef logic [FILL_BITS-1:0]          fill_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic    evict;
    logic    insert;
    sample_t key;
    age_t    oldest_age;
  } cell_cmd_t;

endpackage

// File: rtl/sliding_window_median_core.sv
// Top level of the sliding window median core: sequencer, chain of cells, output register.
// Depends on swm_pkg, swm_cell and sliding_window_median_core_macros.svh.
`timescale 1ns / 1ps
//
// Channel   Handshake             Payload
// input     in_valid / in_ready   sample, last_sample
// output    out_valid / out_ready median_value, sequence_end
// config    cfg_wr_en             cfg_wr_data (window size)
//
// A sample needs k evictions, where k is 1 once the window is full, 0 while filling and
// more after the window shrinks: the sequencer moves the chain by one eviction per cycle,
// then the insert state and the result state follow; a new sample waits until idle.
// Reset is synchronous; it empties the window and sets the window size to 3.
// The result cycle stalls only while the output register still holds an untaken word.

module sliding_window_median_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  swm_pkg::sample_t        sample,
  input  logic                    last_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output swm_pkg::sample_t        median_value,
  output logic                    sequence_end,
  input  logic                    cfg_wr_en,
  input  logic [6:0]              cfg_wr_data
);

  localparam int unsigned WMAX = swm_pkg::WINDOW_MAX;
  localparam int unsigned FB   = swm_pkg::FILL_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVICT  = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]         state;
  swm_pkg::fill_t     fill;
  swm_pkg::fill_t     window_size;
  swm_pkg::sample_t   key;
  logic               last_flag;

  swm_pkg::fill_t     w_eff;
  swm_pkg::fill_t     w_m1;
  logic [swm_pkg::IDX_BITS-1:0] mid;
  logic               out_free;
  logic               emit_word;

  swm_pkg::cell_cmd_t cmd;
  swm_pkg::sample_t   cell_val [WMAX];
  swm_pkg::age_t      cell_age [WMAX];
  logic [WMAX-1:0]    live;
  logic [WMAX-1:0]    le;
  logic [WMAX-1:0]    rm;

  always_comb begin
    if (window_size == '0) begin
      w_eff = FB'(1);
    end else if (window_size > FB'(WMAX)) begin
      w_eff = FB'(WMAX);
    end else begin
      w_eff = window_size;
    end
  end

  assign w_m1      = w_eff - FB'(1);
  assign mid       = w_m1[swm_pkg::IDX_BITS:1];
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign emit_word = (state == ST_EMIT) && (fill == w_eff) && out_free;

  always_comb begin
    cmd.evict      = (state == ST_EVICT) && (fill >= w_eff);
    cmd.insert     = (state == ST_INSERT);
    cmd.key        = key;
    cmd.oldest_age = swm_pkg::age_t'(fill - FB'(1));
  end

  for (genvar i = 0; i < WMAX; i++) begin : g_cell
    swm_pkg::sample_t lv;
    swm_pkg::age_t    la;
    logic             lle;
    logic             rmi;
    swm_pkg::sample_t rv;
    swm_pkg::age_t    ra;

    assign live[i] = (FB'(i) < fill);

    if (i == 0) begin : g_first
      assign lv  = key;
      assign la  = '0;
      assign lle = 1'b1;
      assign rmi = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign la  = cell_age[i-1];
      assign lle = le[i-1];
      assign rmi = rm[i-1];
    end

    if (i == WMAX - 1) begin : g_last
      assign rv = cell_val[i];
      assign ra = cell_age[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
      assign ra = cell_age[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (live[i]),
      .left_val  (lv),
      .left_age  (la),
      .left_le   (lle),
      .right_val (rv),
      .right_age (ra),
      .rm_in     (rmi),
      .rm_out    (rm[i]),
      .le_out    (le[i]),
      .val       (cell_val[i]),
      .age       (cell_age[i])
    );
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      window_size <= swm_pkg::WINDOW_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (emit_word) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (fill >= w_eff) begin
            fill <= fill - FB'(1);
          end else begin
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          fill  <= fill + FB'(1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (fill != w_eff || out_free) begin
            if (last_flag) begin
              fill <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key       <= sample;
      last_flag <= last_sample;
    end
    if (emit_word) begin
      median_value <= cell_val[mid];
      sequence_end <= last_flag;
    end
  end

`include "sliding_window_median_core_macros.svh"

  `SWM_ASSERT_ALWAYS(a_fill_cap, fill <= FB'(WMAX), "fill count exceeds the chain length")
  `SWM_ASSERT_NEXT(a_insert_grows, state == ST_INSERT, fill == $past(fill) + FB'(1), "fill lost")
  `SWM_ASSERT_NEXT(a_out_only_from_emit, state != ST_EMIT && !out_valid, !out_valid, "stray word")

endmodule

// File: rtl/swm_cell.sv
// One cell of the sorted chain: holds one sample and its age.
// Depends on swm_pkg; instantiated by sliding_window_median_core.
`timescale 1ns / 1ps

module swm_cell (
  input  logic                clk,
  input  swm_pkg::cell_cmd_t  cmd,
  input  logic                live,
  input  swm_pkg::sample_t    left_val,
  input  swm_pkg::age_t       left_age,
  input  logic                left_le,
  input  swm_pkg::sample_t    right_val,
  input  swm_pkg::age_t       right_age,
  input  logic                rm_in,
  output logic                rm_out,
  output logic                le_out,
  output swm_pkg::sample_t    val,
  output swm_pkg::age_t       age
);

  logic hit;

  assign hit    = live && (age == cmd.oldest_age);
  assign rm_out = rm_in | hit;
  assign le_out = live && (val <= cmd.key);

  // Eviction pulls everything right of the oldest word one place left;
  // insertion pushes everything above the new key one place right.
  always_ff @(posedge clk) begin
    if (cmd.evict) begin
      if (rm_out) begin
        val <= right_val;
        age <= right_age;
      end
    end else if (cmd.insert) begin
      if (le_out) begin
        age <= age + swm_pkg::age_t'(1);
      end else if (left_le) begin
        val <= cmd.key;
        age <= '0;
      end else begin
        val <= left_val;
        age <= left_age + swm_pkg::age_t'(1);
      end
    end
  end

endmodule
